// ===== rtl/assert_macros.svh =====
// Assertion macros for the hash table RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/bhti_pkg.sv =====
// Package with sizes, status codes and shared types of the bucketed hash table.
package bhti_pkg;

    // Table geometry.
    localparam int BUCKETS  = 16;
    localparam int SLOTS    = 8;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Payload widths.
    localparam int KEY_W    = 31;
    localparam int REF_W    = 32;
    localparam int PRICE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int BOUT_W   = 4;
    localparam int SOUT_W   = 3;
    localparam int COUNT_W  = 8;

    // Reciprocal for the home bucket computation: floor(2^S / BUCKETS).
    localparam int          RECIP_SHIFT = KEY_W + BUCKET_W;
    localparam logic [31:0] RECIP_MUL   = 32'(((64'd1) << RECIP_SHIFT) / BUCKETS);
    localparam int          REM_W       = BUCKET_W + 1;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HOME     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    // Outcome of comparing one bucket row against the search key.
    typedef struct packed {
        logic              found;
        logic              dup;
        logic [SLOT_W-1:0] slot;
    } t_probe;

    // Store request into one slot.
    typedef struct packed {
        logic                en;
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
        logic [REF_W-1:0]    name_ref;
        logic [PRICE_W-1:0]  price;
    } t_store_wr;

endpackage

// ===== rtl/bhti_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface bhti_in_if;
    import bhti_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [REF_W-1:0]   name_ref;
    logic [PRICE_W-1:0] price_bits;

    modport source (output valid, output op, output key, output name_ref,
                    output price_bits, input ready);
    modport sink   (input valid, input op, input key, input name_ref,
                    input price_bits, output ready);
endinterface

interface bhti_out_if;
    import bhti_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BOUT_W-1:0]   bucket_used;
    logic [SOUT_W-1:0]   slot_used;
    logic [COUNT_W-1:0]  occupied_count;

    modport source (output valid, output status, output bucket_used, output slot_used,
                    output occupied_count, input ready);
    modport sink   (input valid, input status, input bucket_used, input slot_used,
                    input occupied_count, output ready);
endinterface

// ===== rtl/bhti_hash.sv =====
// Home bucket unit: key modulo BUCKETS through a reciprocal multiply and one correction.
module bhti_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bhti_pkg::KEY_W-1:0]    i_key,
    output logic                          o_done,
    output logic [bhti_pkg::BUCKET_W-1:0] o_home
);
    import bhti_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_quot;
    logic [REM_W-1:0] r_rem;
    logic             r_v1;
    logic             r_v2;
    logic [62:0]      prod;
    logic [REM_W-1:0] rem;

    // First stage: estimated quotient, exact or one too small.
    assign prod = 63'(i_key) * 63'(RECIP_MUL);

    // Second stage: remainder estimate, below twice BUCKETS, low bits only.
    assign rem = REM_W'(r_key) - REM_W'(r_quot) * REM_W'(BUCKETS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_quot <= KEY_W'(prod >> RECIP_SHIFT);
        end
        if (r_v1) begin
            r_rem <= rem;
        end
    end

    // Final correction: one compare and subtract.
    assign o_done = r_v2;
    assign o_home = (r_rem >= REM_W'(BUCKETS)) ? BUCKET_W'(r_rem - REM_W'(BUCKETS))
                                               : BUCKET_W'(r_rem);
endmodule

// ===== rtl/bhti_store.sv =====
// Slot store: key memory by bucket row, valid bits, record memories and row compare unit.
module bhti_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [bhti_pkg::BUCKET_W-1:0] i_rd_bucket,
    input  logic [bhti_pkg::KEY_W-1:0]    i_key,
    input  bhti_pkg::t_store_wr           i_wr,
    output bhti_pkg::t_probe              o_probe
);
    import bhti_pkg::*;

    logic [KEY_W-1:0]   mem_key   [BUCKETS][SLOTS];
    logic [REF_W-1:0]   mem_ref   [BUCKETS][SLOTS];
    logic [PRICE_W-1:0] mem_price [BUCKETS][SLOTS];
    logic [SLOTS-1:0]   r_valid   [BUCKETS];
    logic [KEY_W-1:0]   r_row     [SLOTS];
    logic [SLOTS-1:0]   r_row_vld;
    logic [SLOTS-1:0]   hit;
    logic [SLOTS-1:0]   match;
    t_probe             probe;

    // Memory write into one slot of a row, and registered row read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_key[i_wr.bucket][i_wr.slot]   <= i_wr.key;
            mem_ref[i_wr.bucket][i_wr.slot]   <= i_wr.name_ref;
            mem_price[i_wr.bucket][i_wr.slot] <= i_wr.price;
        end
        r_row     <= mem_key[i_rd_bucket];
        r_row_vld <= r_valid[i_rd_bucket];
    end

    // Valid bits: cleared together by reset or a clear operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int b = 0; b < BUCKETS; b++) begin
                r_valid[b] <= '0;
            end
        end else if (i_wr.en) begin
            r_valid[i_wr.bucket][i_wr.slot] <= 1'b1;
        end
    end

    // Per-slot compare: an invalid slot reads as empty.
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            match[s] = r_row_vld[s] && (r_row[s] == i_key);
            hit[s]   = !r_row_vld[s] || match[s];
        end
    end

    // First slot that either matches or is empty.
    always_comb begin
        probe = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (hit[s]) begin
                probe.found = 1'b1;
                probe.dup   = match[s];
                probe.slot  = SLOT_W'(s);
            end
        end
    end

    assign o_probe = probe;
endmodule

// ===== rtl/bucketed_hash_table_insert.sv =====
// Top level of the bucketed hash table: request sequencer, bucket probe and result register.
//
//  channel  | dir | transfer payload
//  ---------+-----+-------------------------------------------------
//  i_in     | in  | op, key, name_ref, price_bits
//  o_out    | out | status, bucket_used, slot_used, occupied_count
//
// A clear or a zero key goes from the transfer to S_DONE, then through the output register to a valid result.
// An insert passes through the home bucket arithmetic, then probes P buckets (1 to BUCKETS),
// one bucket row per cycle through the key memory read port, then loads the result
// register once the output register is free.
// i_in.ready is high only while the sequencer is idle; a result waits in the output
// register while the next request is taken. Reset empties the table at once.
`include "assert_macros.svh"

module bucketed_hash_table_insert (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhti_in_if.sink    i_in,
    bhti_out_if.source o_out
);
    import bhti_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HASH = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [KEY_W-1:0]    r_key;
    logic [REF_W-1:0]    r_name;
    logic [PRICE_W-1:0]  r_price;
    logic [BUCKET_W-1:0] r_home;
    logic [BUCKET_W-1:0] r_cur;
    logic [BUCKET_W-1:0] r_probes;
    logic [COUNT_W-1:0]  r_fill;
    logic [STATUS_W-1:0] r_res_status;
    logic [BUCKET_W-1:0] r_res_bucket;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [BOUT_W-1:0]   r_out_bucket;
    logic [SOUT_W-1:0]   r_out_slot;
    logic [COUNT_W-1:0]  r_out_count;

    logic                accept;
    logic                clear;
    logic                hash_start;
    logic                hash_done;
    logic [BUCKET_W-1:0] hash_home;
    logic [BUCKET_W-1:0] next_cur;
    logic [BUCKET_W-1:0] rd_bucket;
    logic                last_probe;
    logic                out_load;
    t_probe              probe;
    t_store_wr           wr;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign clear      = accept && (i_in.op == OP_CLEAR);
    assign hash_start = accept && (i_in.op == OP_INSERT) && (i_in.key != '0);

    // Probe address: home bucket first, then the next bucket with wrap-around.
    assign next_cur   = (r_cur == BUCKET_W'(BUCKETS - 1)) ? '0 : r_cur + 1'b1;
    assign rd_bucket  = (r_state == S_HASH) ? hash_home : next_cur;
    assign last_probe = (r_probes == BUCKET_W'(BUCKETS - 1));

    bhti_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_in.key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    // Store into the first empty slot found by the probe.
    always_comb begin
        wr          = '0;
        wr.en       = (r_state == S_SCAN) && probe.found && !probe.dup;
        wr.bucket   = r_cur;
        wr.slot     = probe.slot;
        wr.key      = r_key;
        wr.name_ref = r_name;
        wr.price    = r_price;
    end

    bhti_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_rd_bucket (rd_bucket),
        .i_key       (r_key),
        .i_wr        (wr),
        .o_probe     (probe)
    );

    // Next-state logic.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (hash_start) begin
                    n_state = S_HASH;
                end else if (accept) begin
                    n_state = S_DONE;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (probe.found || last_probe) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clear) begin
                r_fill <= '0;
            end else if (wr.en) begin
                r_fill <= r_fill + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, probe position and result fields.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key        <= i_in.key;
            r_name       <= i_in.name_ref;
            r_price      <= i_in.price_bits;
            r_res_bucket <= '0;
            r_res_slot   <= '0;
            r_res_status <= (i_in.op == OP_CLEAR) ? ST_CLEARED : ST_DUP;
        end
        if ((r_state == S_HASH) && hash_done) begin
            r_home   <= hash_home;
            r_cur    <= hash_home;
            r_probes <= '0;
        end
        if (r_state == S_SCAN) begin
            if (probe.found && probe.dup) begin
                r_res_status <= ST_DUP;
                r_res_bucket <= r_home;
                r_res_slot   <= '0;
            end else if (probe.found) begin
                r_res_status <= (r_cur == r_home) ? ST_HOME : ST_OVERFLOW;
                r_res_bucket <= r_cur;
                r_res_slot   <= probe.slot;
            end else if (last_probe) begin
                r_res_status <= ST_FULL;
                r_res_bucket <= r_home;
                r_res_slot   <= '0;
            end else begin
                r_cur    <= next_cur;
                r_probes <= r_probes + 1'b1;
            end
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_bucket <= BOUT_W'(r_res_bucket);
            r_out_slot   <= SOUT_W'(r_res_slot);
            r_out_count  <= r_fill;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.bucket_used    = r_out_bucket;
    assign o_out.slot_used      = r_out_slot;
    assign o_out.occupied_count = r_out_count;

    // The sequencer drops ready for the cycle after each request transfer.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_in.ready)
    // A store bumps the occupancy count by exactly one.
    `ASSERT_NEXT(a_fill_on_store, i_clk, i_rst_n, wr.en, r_fill == $past(r_fill) + 1'b1)
    // The home bucket unit never returns an index beyond the table.
    `ASSERT_IMPL(a_home_range, i_clk, i_rst_n, hash_done, int'(hash_home) < BUCKETS)
    // A store only lands while a probe of a nonzero key is running.
    `ASSERT_IMPL(a_store_key, i_clk, i_rst_n, wr.en, (r_state == S_SCAN) && (r_key != '0))

endmodule

// ===== test/bucketed_hash_table_insert_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bucketed_hash_table_insert, with a scoreboard that mirrors the table.
module bucketed_hash_table_insert_test;
    import bhti_pkg::*;

    localparam int TABLE_SLOTS = BUCKETS * SLOTS;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_START = 2000;
    localparam int HOLD_CYCLES = 300;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BOUT_W-1:0]   bucket;
        logic [SOUT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } t_insert_result;

    // Mirror of the table contents and the queue of results it predicts.
    class t_insert_scoreboard;
        logic [KEY_W-1:0] table_keys [TABLE_SLOTS];
        int unsigned      fill;
        t_insert_result   pending_results [$];
        int unsigned      errors;
        int unsigned      status_seen [5];

        function new();
            foreach (table_keys[i]) table_keys[i] = '0;
            fill = 0;
            errors = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Apply one accepted request to the mirror and queue its result.
        function void note_request(logic op, logic [KEY_W-1:0] key);
            int unsigned    home;
            int unsigned    b;
            int unsigned    idx;
            bit             done;
            t_insert_result res;

            if (op == OP_CLEAR) begin
                foreach (table_keys[i]) table_keys[i] = '0;
                fill = 0;
                res = '{ST_CLEARED, '0, '0, '0};
            end else begin
                home = key % BUCKETS;
                res.status = ST_DUP;
                res.bucket = BOUT_W'(home);
                res.slot = '0;
                // Probe buckets from home with wrap-around, slot by slot.
                if (key != '0) begin
                    res.status = ST_FULL;
                    done = 1'b0;
                    for (int n = 0; n < BUCKETS && !done; n++) begin
                        b = (home + n) % BUCKETS;
                        for (int s = 0; s < SLOTS && !done; s++) begin
                            idx = b * SLOTS + s;
                            if (table_keys[idx] == key) begin
                                res.status = ST_DUP;
                                done = 1'b1;
                            end else if (table_keys[idx] == '0) begin
                                table_keys[idx] = key;
                                fill = (fill + 1) % 256;
                                res.status = (b == home) ? ST_HOME : ST_OVERFLOW;
                                res.bucket = BOUT_W'(b);
                                res.slot = SOUT_W'(s);
                                done = 1'b1;
                            end
                        end
                    end
                end
                res.count = COUNT_W'(fill);
            end
            pending_results.push_back(res);
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(t_insert_result got);
            t_insert_result exp;

            if (pending_results.size() == 0) begin
                $error("result with no request waiting: status %0d", got.status);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status < 5) status_seen[got.status]++;
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.bucket !== exp.bucket) begin
                $error("bucket_used: expected %0d, got %0d", exp.bucket, got.bucket);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $error("slot_used: expected %0d, got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.count !== exp.count) begin
                $error("occupied_count: expected %0d, got %0d", exp.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bhti_in_if  in_ch ();
    bhti_out_if out_ch ();

    t_insert_scoreboard board = new();
    int unsigned        sent = 0;
    int unsigned        fills_done = 0;

    bucketed_hash_table_insert DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Offer one request, with random idle cycles ahead of it, and wait for its transfer.
    task automatic send_request(logic op, logic [KEY_W-1:0] key,
                                logic [REF_W-1:0] nref, logic [PRICE_W-1:0] price);
        bit gaps_on;

        gaps_on = !(sent >= 700 && sent < 1000);
        if (gaps_on && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 27);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.key        <= key;
        in_ch.name_ref   <= nref;
        in_ch.price_bits <= price;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_request(op, key);
        sent++;
    endtask

    task automatic insert_key(logic [KEY_W-1:0] key);
        send_request(OP_INSERT, key, $urandom(), $urandom());
    endtask

    // A clear carries random key and payload bits, which the block must ignore.
    task automatic clear_table();
        send_request(OP_CLEAR, KEY_W'($urandom()), $urandom(), $urandom());
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;

        k = KEY_W'($urandom());
        if (k == '0) k = KEY_W'(1);
        return k;
    endfunction

    // Fill the table to the last slot, then push more keys against the full table.
    task automatic fill_table_run();
        logic [KEY_W-1:0] stored [$];
        logic [KEY_W-1:0] k;

        clear_table();
        while (board.fill < TABLE_SLOTS) begin
            if (stored.size() > 0 && $urandom_range(99) < 10)
                k = stored[$urandom_range(stored.size() - 1)];
            else
                k = random_key();
            insert_key(k);
            stored.push_back(k);
        end
        fills_done++;
        repeat ($urandom_range(12, 4)) begin
            case ($urandom_range(2))
                0: insert_key(random_key());
                1: insert_key('0);
                default: insert_key(stored[$urandom_range(stored.size() - 1)]);
            endcase
        end
    endtask

    // A short run of inserts biased toward one home bucket, with repeats and noise.
    task automatic mixed_run();
        logic [KEY_W-1:0] live [$];
        logic [KEY_W-1:0] k;
        int unsigned      focus;
        int unsigned      pick;

        if ($urandom_range(99) < 80) clear_table();
        focus = $urandom_range(BUCKETS - 1);
        repeat ($urandom_range(60, 5)) begin
            pick = $urandom_range(99);
            if (pick >= 95) begin
                clear_table();
                live.delete();
            end else begin
                if (pick < 40)
                    k = KEY_W'($urandom_range(11) * BUCKETS + focus);
                else if (pick < 62 && live.size() > 0)
                    k = live[$urandom_range(live.size() - 1)];
                else if (pick < 88)
                    k = random_key();
                else if (pick < 92)
                    k = '0;
                else
                    k = {KEY_W{1'b1}};
                insert_key(k);
                live.push_back(k);
            end
        end
    endtask

    // Result side: random back-pressure, one long hold-off, and a stretch always ready.
    initial begin
        int unsigned rx_cycle;

        rx_cycle = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_cycle += HOLD_CYCLES;
            end
            if (rx_cycle >= 9000 && rx_cycle < 12000)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= 27);
        end
    end

    // Check every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(t_insert_result'{out_ch.status, out_ch.bucket_used,
                                                out_ch.slot_used, out_ch.occupied_count});
    end

    // Stimulus and end of run.
    initial begin
        int unsigned run_idx;

        run_idx = 0;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_INSERT;
        in_ch.key        <= '0;
        in_ch.name_ref   <= '0;
        in_ch.price_bits <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero key on an empty table, then the largest key with all-ones payload.
        insert_key('0);
        send_request(OP_INSERT, {KEY_W{1'b1}}, '1, '1);
        send_request(OP_INSERT, {KEY_W{1'b1}}, '0, '0);
        send_request(OP_INSERT, KEY_W'(1), '0, '0);
        insert_key(KEY_W'(32'h5555_5555));
        insert_key(KEY_W'(32'h2AAA_AAAA));
        // Fill the last bucket and spill over the wrap into bucket zero.
        for (int i = 0; i < SLOTS; i++) insert_key(KEY_W'(i * BUCKETS + BUCKETS - 1));
        insert_key(KEY_W'(BUCKETS));
        // Repeat of a key that sits in an overflow bucket.
        insert_key(KEY_W'((SLOTS - 1) * BUCKETS + BUCKETS - 1));
        send_request(OP_CLEAR, {KEY_W{1'b1}}, '1, '1);
        insert_key('0);
        insert_key(KEY_W'(BUCKETS - 1));

        // Random runs; every fifth one fills the table completely.
        while (sent < RANDOM_ITEMS) begin
            if (run_idx % 5 == 2)
                fill_table_run();
            else
                mixed_run();
            run_idx++;
        end
        in_ch.valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests; %0d full-table fills and a %0d-cycle output hold-off.",
                 sent, fills_done, HOLD_CYCLES);
        $display("Results: %0d home, %0d overflow, %0d duplicate, %0d full, %0d cleared.",
                 board.status_seen[ST_HOME], board.status_seen[ST_OVERFLOW],
                 board.status_seen[ST_DUP], board.status_seen[ST_FULL],
                 board.status_seen[ST_CLEARED]);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("[bucketed_hash_table_insert] OK");
        else
            $display("[bucketed_hash_table_insert] ERROR");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("[bucketed_hash_table_insert] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bhti_pkg.sv
rtl/bhti_if.sv
rtl/bhti_hash.sv
rtl/bhti_store.sv
rtl/bucketed_hash_table_insert.sv
test/bucketed_hash_table_insert_test.sv
